@@ hw/rtl/tspa_pkg.sv @@
// tspa_pkg: shared types, constants and conversion helpers of the
// temperature poll and average block; no dependencies
`default_nettype none

package tspa_pkg;

    localparam int TEMP_C_W   = 12;
    localparam int TEMP_F_W   = 15;
    localparam int MS_W       = 16;
    localparam int OFFSET_W   = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [MS_W-1:0]            RESET_READ_DELAY = 16'd250;
    localparam logic [MS_W-1:0]            RESET_PERIOD     = 16'd1000;
    localparam logic signed [TEMP_F_W-1:0] RESET_TEMP_F     = 15'sd8000;

    // valid primary range, strictly between -50 C and 85 C in 1/16 C
    localparam logic signed [TEMP_C_W-1:0] C16_LOW  = -12'sd800;
    localparam logic signed [TEMP_C_W-1:0] C16_HIGH = 12'sd1360;
    // 32 F in 1/80 F
    localparam logic signed [TEMP_F_W:0]   F80_OFFSET = 16'sd2560;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_READ_DELAY        = 2'd0,
        CFG_SAMPLE_PERIOD     = 2'd1,
        CFG_CAL_OFFSET        = 2'd2,
        CFG_SECONDARY_PRESENT = 2'd3
    } cfg_index_e;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_DIV,
        BK_FIN,
        BK_EMIT
    } back_state_t;

    // one tick, classified by the front end
    typedef struct packed {
        logic                        req;
        logic                        done;
        logic                        p_valid;
        logic signed [TEMP_F_W-1:0]  raw_f;
        logic                        sec_upd;
        logic signed [TEMP_F_W-1:0]  sec_f;
    } job_t;

    function automatic logic in_range(input logic signed [TEMP_C_W-1:0] c16);
        return (c16 > C16_LOW) && (c16 < C16_HIGH);
    endfunction

    // c16 * 9 + 2560, exact for in-range readings
    function automatic logic signed [TEMP_F_W-1:0] to_f80(
        input logic signed [TEMP_C_W-1:0] c16);
        logic signed [TEMP_F_W:0] ext;
        logic signed [TEMP_F_W:0] prod;
        ext  = {{(TEMP_F_W+1-TEMP_C_W){c16[TEMP_C_W-1]}}, c16};
        prod = (ext <<< 3) + ext + F80_OFFSET;
        return prod[TEMP_F_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tspa_if.sv @@
// tspa_if: valid/ready stream interfaces for the tick input and the result
// output; depends on tspa_pkg for field widths
`default_nettype none

interface tspa_in_if import tspa_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic signed [TEMP_C_W-1:0]  primary_temp_c;
    logic signed [TEMP_C_W-1:0]  secondary_temp_c;

    modport source (output valid, output primary_temp_c, output secondary_temp_c,
                    input ready);
    modport sink   (input valid, input primary_temp_c, input secondary_temp_c,
                    output ready);
endinterface

interface tspa_out_if import tspa_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic                        request_conversion;
    logic                        read_done;
    logic                        sensor_valid;
    logic signed [TEMP_F_W-1:0]  raw_temp_f;
    logic signed [TEMP_F_W-1:0]  filtered_temp_f;
    logic signed [TEMP_F_W-1:0]  secondary_temp_f;

    modport source (output valid, output request_conversion, output read_done,
                    output sensor_valid, output raw_temp_f, output filtered_temp_f,
                    output secondary_temp_f, input ready);
    modport sink   (input valid, input request_conversion, input read_done,
                    input sensor_valid, input raw_temp_f, input filtered_temp_f,
                    input secondary_temp_f, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tspa_ram.sv @@
// tspa_ram: generic single-port ram with registered read
// no dependencies
`default_nettype none

module tspa_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 8
) (
    input  wire logic                                         clk,
    input  wire logic                                         we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                             wdata,
    output logic      [WIDTH-1:0]                             rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/tspa_front.sv @@
// tspa_front: config registers, millisecond pacing and reading classification
// depends on tspa_pkg and tspa_if
`default_nettype none

module tspa_front import tspa_pkg::*; (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    tspa_in_if.sink                         sensor_in,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data,
    output logic                            job_valid,
    input  wire logic                       job_ready,
    output job_t                            job,
    output logic signed [OFFSET_W-1:0]      cal_offset
);
    logic [MS_W-1:0]             read_delay_reg;
    logic [MS_W-1:0]             period_reg;
    logic signed [OFFSET_W-1:0]  offset_reg;
    logic                        sec_present_reg;

    logic [MS_W-1:0]             elapsed_reg, elapsed_next;
    logic                        pending_reg, pending_next;
    logic [MS_W-1:0]             el_inc;
    logic                        accept;

    assign accept          = sensor_in.valid & job_ready;
    assign sensor_in.ready = job_ready;
    assign job_valid       = sensor_in.valid;
    assign cal_offset      = offset_reg;

    // saturating count, then compare
    assign el_inc = (elapsed_reg == {MS_W{1'b1}}) ? elapsed_reg : elapsed_reg + 1'b1;

    always_comb
    begin
        elapsed_next  = el_inc;
        pending_next  = pending_reg;
        job.req       = 1'b0;
        job.done      = 1'b0;
        if (pending_reg)
        begin
            if (el_inc >= read_delay_reg)
            begin
                job.done     = 1'b1;
                pending_next = 1'b0;
            end
        end
        else if (el_inc >= period_reg)
        begin
            job.req      = 1'b1;
            pending_next = 1'b1;
            elapsed_next = '0;
        end
        job.p_valid = in_range(sensor_in.primary_temp_c);
        job.raw_f   = to_f80(sensor_in.primary_temp_c);
        job.sec_upd = sec_present_reg & in_range(sensor_in.secondary_temp_c);
        job.sec_f   = to_f80(sensor_in.secondary_temp_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg     <= '0;
            pending_reg     <= 1'b1;
            read_delay_reg  <= RESET_READ_DELAY;
            period_reg      <= RESET_PERIOD;
            offset_reg      <= '0;
            sec_present_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                elapsed_reg <= elapsed_next;
                pending_reg <= pending_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index_e'(cfg_index))
                    CFG_READ_DELAY:        read_delay_reg  <= cfg_data[MS_W-1:0];
                    CFG_SAMPLE_PERIOD:     period_reg      <= cfg_data[MS_W-1:0];
                    CFG_CAL_OFFSET:        offset_reg      <= cfg_data[OFFSET_W-1:0];
                    CFG_SECONDARY_PRESENT: sec_present_reg <= cfg_data[0];
                    default:               ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/tspa_queue.sv @@
// tspa_queue: two-entry job queue between front and back end
// depends on tspa_pkg
`default_nettype none

module tspa_queue import tspa_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push_valid,
    output logic        push_ready,
    input  wire job_t   push_data,
    output logic        pop_valid,
    input  wire logic   pop_ready,
    output job_t        pop_data
);
    job_t        entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  fill_reg;
    logic        do_push;
    logic        do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/tspa_back.sv @@
// tspa_back: history ring buffer, running sum, serial floored divide and
// the result register; depends on tspa_pkg, tspa_if and tspa_ram
`default_nettype none

module tspa_back import tspa_pkg::*; #(
    parameter int WINDOW_DEPTH = 8
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       job_valid,
    output logic                            job_ready,
    input  wire job_t                       job,
    input  wire logic signed [OFFSET_W-1:0] cal_offset,
    tspa_out_if.source                      result_out
);
    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = TEMP_F_W + 1 + $clog2(WINDOW_DEPTH);
    localparam int STEP_W = $clog2(SUM_W + 1);
    localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(WINDOW_DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(WINDOW_DEPTH - 1);
    localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(SUM_W - 1);

    back_state_t                 state_reg, state_next;

    logic                        req_reg, done_reg, valid_reg;
    logic signed [TEMP_F_W-1:0]  raw_reg, filt_reg, sec_reg;
    logic [SLOT_W-1:0]           slot_reg;
    logic [CNT_W-1:0]            count_reg;
    logic signed [SUM_W-1:0]     sum_reg;

    logic [CNT_W-1:0]            rem_reg;
    logic [SUM_W-1:0]            quo_reg;
    logic [STEP_W-1:0]           step_reg;
    logic                        neg_reg;

    logic                        out_valid_reg;
    logic                        out_req_reg, out_done_reg, out_sv_reg;
    logic signed [TEMP_F_W-1:0]  out_raw_reg, out_filt_reg, out_sec_reg;

    // fsm outputs
    logic                        ld_job, ram_we, div_load, div_step, fin, emit;
    logic                        out_free;

    logic [TEMP_F_W-1:0]         ram_rdata;
    logic signed [SUM_W-1:0]     old_val;
    logic signed [SUM_W-1:0]     sum_new;
    logic [SUM_W-1:0]            sum_mag;
    logic [CNT_W:0]              trial;
    logic                        trial_ge;
    logic [CNT_W:0]              trial_sub;
    logic signed [SUM_W:0]       q_pos;
    logic signed [SUM_W:0]       q_floor;
    logic signed [TEMP_F_W-1:0]  filt_new;

    tspa_ram #(
        .WIDTH (TEMP_F_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .addr  (slot_reg),
        .wdata (raw_reg),
        .rdata (ram_rdata)
    );

    assign out_free = ~out_valid_reg | result_out.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = (job.done && job.p_valid) ? BK_READ : BK_EMIT;
                end
            end
            BK_READ: state_next = BK_DIV;
            BK_DIV:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = BK_FIN;
                end
            end
            BK_FIN: state_next = BK_EMIT;
            BK_EMIT:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // fsm outputs
    always_comb
    begin
        job_ready = (state_reg == BK_IDLE);
        ld_job    = (state_reg == BK_IDLE) & job_valid;
        ram_we    = (state_reg == BK_READ);
        div_load  = (state_reg == BK_READ);
        div_step  = (state_reg == BK_DIV);
        fin       = (state_reg == BK_FIN);
        emit      = (state_reg == BK_EMIT) & out_free;
    end

    // running sum: add the new sample, drop the one it overwrites once full
    always_comb
    begin
        old_val = (count_reg == FULL_COUNT)
                ? {{(SUM_W-TEMP_F_W){ram_rdata[TEMP_F_W-1]}}, ram_rdata}
                : '0;
        sum_new = sum_reg + {{(SUM_W-TEMP_F_W){raw_reg[TEMP_F_W-1]}}, raw_reg} - old_val;
        sum_mag = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
    end

    // restoring divide, one quotient bit a cycle
    always_comb
    begin
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        trial_ge  = (trial >= {1'b0, count_reg});
        trial_sub = trial - {1'b0, count_reg};
    end

    // floor for negative sums, then the calibration offset
    always_comb
    begin
        q_pos    = {1'b0, quo_reg};
        q_floor  = neg_reg ? (-q_pos - {{SUM_W{1'b0}}, (rem_reg != '0)}) : q_pos;
        filt_new = q_floor[TEMP_F_W-1:0]
                 + {{(TEMP_F_W-OFFSET_W){cal_offset[OFFSET_W-1]}}, cal_offset};
    end

    always_ff @(posedge clk)
    begin
        if (div_load)
        begin
            rem_reg  <= '0;
            quo_reg  <= sum_mag;
            neg_reg  <= sum_new[SUM_W-1];
        end
        else if (div_step)
        begin
            rem_reg  <= trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_reg  <= {quo_reg[SUM_W-2:0], trial_ge};
        end
        if (ld_job)
        begin
            req_reg  <= job.req;
            done_reg <= job.done;
        end
        if (emit)
        begin
            out_req_reg  <= req_reg;
            out_done_reg <= done_reg;
            out_sv_reg   <= valid_reg;
            out_raw_reg  <= raw_reg;
            out_filt_reg <= filt_reg;
            out_sec_reg  <= sec_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            valid_reg     <= 1'b0;
            raw_reg       <= RESET_TEMP_F;
            filt_reg      <= RESET_TEMP_F;
            sec_reg       <= RESET_TEMP_F;
            slot_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ld_job && job.done)
            begin
                valid_reg <= job.p_valid;
                if (job.p_valid)
                begin
                    raw_reg <= job.raw_f;
                    if (job.sec_upd)
                    begin
                        sec_reg <= job.sec_f;
                    end
                end
            end
            if (div_load)
            begin
                sum_reg  <= sum_new;
                slot_reg <= (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                if (count_reg != FULL_COUNT)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                step_reg <= '0;
            end
            else if (div_step)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (fin)
            begin
                filt_reg <= filt_new;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_out.valid              = out_valid_reg;
    assign result_out.request_conversion = out_req_reg;
    assign result_out.read_done          = out_done_reg;
    assign result_out.sensor_valid       = out_sv_reg;
    assign result_out.raw_temp_f         = out_raw_reg;
    assign result_out.filtered_temp_f    = out_filt_reg;
    assign result_out.secondary_temp_f   = out_sec_reg;

endmodule

`default_nettype wire

@@ hw/rtl/temp_sensor_poll_and_average.sv @@
// temp_sensor_poll_and_average: top level of the sensor poll and moving average
// block; depends on tspa_pkg, tspa_if, tspa_front, tspa_queue and tspa_back
//
// usage
//  - sensor_in carries one beat per millisecond tick with both raw readings
//    in 1/16 C; result_out returns exactly one beat per tick with the request
//    and read strobes, the valid flag and the three temperatures in 1/80 F
//  - cfg_we/cfg_index/cfg_data write the delay, period, offset and
//    second-sensor registers; write them only while no tick is in flight
//  - the front end takes a tick per cycle while its two-entry job queue has
//    room; the back end passes a tick that pushes no sample through its idle
//    and emit states, and one that does through read, a divide step per
//    quotient bit, finish and emit; the serial divide forms the floored mean
//  - a tick's result may also wait behind earlier jobs in the queue
//  - a stalled result_out holds its beat in the output register; the back end
//    still drains one more job behind it and then the queue fills and
//    sensor_in.ready drops
//  - reset restores the register defaults, starts with a conversion already
//    pending and clears the sample window; no clearing pass is needed
`default_nettype none

module temp_sensor_poll_and_average import tspa_pkg::*; #(
    parameter int WINDOW_DEPTH = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    tspa_in_if.sink                     sensor_in,
    tspa_out_if.source                  result_out,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);
    // front to queue
    logic                        fq_valid;
    logic                        fq_ready;
    job_t                        fq_job;
    // queue to back
    logic                        qb_valid;
    logic                        qb_ready;
    job_t                        qb_job;
    logic signed [OFFSET_W-1:0]  cal_offset;

    // pacing counter and classification of each tick
    tspa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sensor_in  (sensor_in),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .job_valid  (fq_valid),
        .job_ready  (fq_ready),
        .job        (fq_job),
        .cal_offset (cal_offset)
    );

    // decouples the combinational front from the serial, state-machine back end
    tspa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_job)
    );

    // window update, divide and result register
    tspa_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (qb_valid),
        .job_ready  (qb_ready),
        .job        (qb_job),
        .cal_offset (cal_offset),
        .result_out (result_out)
    );

endmodule

`default_nettype wire
